@@ hw/rtl/ctse_pkg.sv @@
`timescale 1ns / 1ps

package ctse_pkg;

    // field storage
    localparam int FLD_N = 7;
    localparam int FLD_W = 7;
    localparam int CUR_W = 3;

    // field slots, also the cursor values
    localparam logic [CUR_W-1:0] F_YEAR    = 3'd0;
    localparam logic [CUR_W-1:0] F_MONTH   = 3'd1;
    localparam logic [CUR_W-1:0] F_DAY     = 3'd2;
    localparam logic [CUR_W-1:0] F_HOUR    = 3'd3;
    localparam logic [CUR_W-1:0] F_MINUTE  = 3'd4;
    localparam logic [CUR_W-1:0] F_SECOND  = 3'd5;
    localparam logic [CUR_W-1:0] F_WEEKDAY = 3'd6;

    // opcodes
    localparam logic [2:0] OP_TICK = 3'd0;
    localparam logic [2:0] OP_MODE = 3'd1;
    localparam logic [2:0] OP_NEXT = 3'd2;
    localparam logic [2:0] OP_INC  = 3'd3;
    localparam logic [2:0] OP_DEC  = 3'd4;
    localparam logic [2:0] OP_LOAD = 3'd5;

    // field limits
    localparam logic [FLD_W-1:0] YEAR_MAX  = 7'd99;
    localparam logic [FLD_W-1:0] MONTH_MAX = 7'd12;
    localparam logic [FLD_W-1:0] HOUR_MAX  = 7'd23;
    localparam logic [FLD_W-1:0] MIN_MAX   = 7'd59;
    localparam logic [FLD_W-1:0] WDAY_MAX  = 7'd7;

    localparam logic [4:0] DAYS_LONG  = 5'd31;
    localparam logic [4:0] DAYS_SHORT = 5'd30;
    localparam logic [4:0] DAYS_LEAP  = 5'd29;
    localparam logic [4:0] DAYS_FEB   = 5'd28;

    localparam logic [7:0] BLINK_TICKS_RST = 8'd10;

    // one input beat
    typedef struct packed {
        logic [2:0] opcode;
        logic [6:0] load_year;
        logic [3:0] load_month;
        logic [4:0] load_day;
        logic [4:0] load_hour;
        logic [5:0] load_minute;
        logic [5:0] load_second;
        logic [2:0] load_weekday;
    } t_item;

    // days in a month; anything not a 30 or 31 day month counts as February
    function automatic logic [4:0] month_len(input logic [FLD_W-1:0] month,
                                             input logic [FLD_W-1:0] year);
        logic [4:0] len;
        case (month)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = DAYS_LONG;
            7'd4, 7'd6, 7'd9, 7'd11:                   len = DAYS_SHORT;
            default: len = (year[1:0] == 2'b00) ? DAYS_LEAP : DAYS_FEB;
        endcase
        return len;
    endfunction

endpackage

@@ hw/rtl/calendar_time_set_editor_top.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake                      Payload
// in        input      i_in_valid / o_in_stall        i_opcode, i_load_*
// out       output     o_out_valid / i_out_stall      o_year .. o_write_time
// cfg       input      i_cfg_valid / o_cfg_ready      i_cfg_data (blink_ticks)
//
// One beat per cycle while the result is not stalled; a result passes through the
// input register, then the editor state that also serves as result register.
// Synchronous active-low reset clears control state; time fields stay undefined
// until the first load.
// A stalled result holds the editor still; the input register keeps taking one
// more beat, after which o_in_stall rises.
module calendar_time_set_editor_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_opcode,
    input  logic [6:0] i_load_year,
    input  logic [3:0] i_load_month,
    input  logic [4:0] i_load_day,
    input  logic [4:0] i_load_hour,
    input  logic [5:0] i_load_minute,
    input  logic [5:0] i_load_second,
    input  logic [2:0] i_load_weekday,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [6:0] o_year,
    output logic [3:0] o_month,
    output logic [4:0] o_day,
    output logic [4:0] o_hour,
    output logic [5:0] o_minute,
    output logic [5:0] o_second,
    output logic [2:0] o_weekday,
    output logic [2:0] o_selected_field,
    output logic       o_blank_selected,
    output logic       o_in_set_mode,
    output logic       o_write_time,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);
    import ctse_pkg::*;

    t_item w_in_item;
    t_item w_s1_item;
    logic  w_s1_vld;
    logic  w_fire;
    logic  w_out_free;
    logic  w_phase;
    logic  w_mode;
    logic  r_out_vld;

    assign w_in_item.opcode       = i_opcode;
    assign w_in_item.load_year    = i_load_year;
    assign w_in_item.load_month   = i_load_month;
    assign w_in_item.load_day     = i_load_day;
    assign w_in_item.load_hour    = i_load_hour;
    assign w_in_item.load_minute  = i_load_minute;
    assign w_in_item.load_second  = i_load_second;
    assign w_in_item.load_weekday = i_load_weekday;

    // the result slot frees when empty or taken this cycle
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_fire     = w_s1_vld && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= w_fire;
        end
    end

    ctse_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_item     (w_in_item),
        .i_drain    (w_fire),
        .o_in_stall (o_in_stall),
        .o_vld      (w_s1_vld),
        .o_item     (w_s1_item)
    );

    ctse_blink u_blink (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_tick      (w_fire && (w_s1_item.opcode == OP_TICK)),
        .o_phase     (w_phase)
    );

    ctse_edit u_edit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_fire),
        .i_item    (w_s1_item),
        .o_year    (o_year),
        .o_month   (o_month),
        .o_day     (o_day),
        .o_hour    (o_hour),
        .o_minute  (o_minute),
        .o_second  (o_second),
        .o_weekday (o_weekday),
        .o_cursor  (o_selected_field),
        .o_mode    (w_mode),
        .o_wr      (o_write_time)
    );

    assign o_out_valid      = r_out_vld;
    assign o_in_set_mode    = w_mode;
    assign o_blank_selected = w_mode && w_phase;
    assign o_cfg_ready      = 1'b1;

endmodule

@@ hw/rtl/ctse_in_stage.sv @@
`timescale 1ns / 1ps

module ctse_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  ctse_pkg::t_item i_item,
    input  logic           i_drain,
    output logic           o_in_stall,
    output logic           o_vld,
    output ctse_pkg::t_item o_item
);
    import ctse_pkg::*;

    logic   r_vld;
    t_item  r_item;
    logic   w_take;

    // stall only when a held beat cannot move on this cycle
    assign o_in_stall = r_vld && !i_drain;
    assign w_take     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_take) begin
            r_vld <= 1'b1;
        end else if (i_drain) begin
            r_vld <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= i_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

@@ hw/rtl/ctse_blink.sv @@
`timescale 1ns / 1ps

module ctse_blink (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic [7:0] i_cfg_data,
    input  logic       i_tick,
    output logic       o_phase
);
    import ctse_pkg::*;

    logic [7:0] r_ticks;
    logic [7:0] r_cnt;
    logic       r_phase;
    logic [7:0] n_cnt;
    logic       n_phase;
    logic [7:0] w_inc;

    // tick counter, wraps and toggles the phase at the programmed count
    always_comb begin
        w_inc   = r_cnt + 8'd1;
        n_cnt   = r_cnt;
        n_phase = r_phase;
        if (i_tick) begin
            if (w_inc >= r_ticks) begin
                n_cnt   = 8'd0;
                n_phase = !r_phase;
            end else begin
                n_cnt = w_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= BLINK_TICKS_RST;
            r_cnt   <= 8'd0;
            r_phase <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_ticks <= i_cfg_data;
            end
            r_cnt   <= n_cnt;
            r_phase <= n_phase;
        end
    end

    assign o_phase = r_phase;

    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_tick |=> $stable(r_cnt) && $stable(r_phase))
        else $error("blink state moved without a tick");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tick && !i_cfg_valid |=> (r_cnt < r_ticks) || (r_cnt == 8'd0))
        else $error("tick count reached the blink period");

    a_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tick && (w_inc >= r_ticks) |=> r_phase != $past(r_phase))
        else $error("blink phase missed its toggle");

endmodule

@@ hw/rtl/ctse_edit.sv @@
`timescale 1ns / 1ps

module ctse_edit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  ctse_pkg::t_item i_item,
    output logic [6:0]      o_year,
    output logic [3:0]      o_month,
    output logic [4:0]      o_day,
    output logic [4:0]      o_hour,
    output logic [5:0]      o_minute,
    output logic [5:0]      o_second,
    output logic [2:0]      o_weekday,
    output logic [2:0]      o_cursor,
    output logic            o_mode,
    output logic            o_wr
);
    import ctse_pkg::*;

    logic [FLD_W-1:0] r_fld [FLD_N];
    logic [FLD_W-1:0] n_fld [FLD_N];
    logic [CUR_W-1:0] r_cursor;
    logic [CUR_W-1:0] n_cursor;
    logic             r_mode;
    logic             n_mode;
    logic             r_wr;
    logic             n_wr;
    logic [4:0]       w_len;
    logic [2:0]       w_op;

    assign w_op = i_item.opcode;

    // one step of the editor: key handling, with a range fix-up of every field after an increment or decrement
    always_comb begin
        n_fld    = r_fld;
        n_cursor = r_cursor;
        n_mode   = r_mode;
        n_wr     = 1'b0;
        w_len    = DAYS_FEB;
        case (w_op)
            OP_MODE: begin
                n_mode = !r_mode;
                n_wr   = !r_mode;
            end
            OP_NEXT: begin
                if (r_mode) begin
                    n_cursor = (r_cursor == F_WEEKDAY) ? F_YEAR : r_cursor + 3'd1;
                    n_wr     = 1'b1;
                end
            end
            OP_INC: begin
                if (r_mode) begin
                    n_fld[r_cursor] = r_fld[r_cursor] + 7'd1;
                    if (n_fld[F_YEAR] > YEAR_MAX)   n_fld[F_YEAR] = 7'd0;
                    if (n_fld[F_MONTH] > MONTH_MAX) n_fld[F_MONTH] = 7'd1;
                    w_len = month_len(n_fld[F_MONTH], n_fld[F_YEAR]);
                    if (n_fld[F_DAY] > {2'b00, w_len}) n_fld[F_DAY] = 7'd1;
                    if (n_fld[F_HOUR] > HOUR_MAX)     n_fld[F_HOUR] = 7'd0;
                    if (n_fld[F_MINUTE] > MIN_MAX)    n_fld[F_MINUTE] = 7'd0;
                    if (n_fld[F_SECOND] > MIN_MAX)    n_fld[F_SECOND] = 7'd0;
                    if (n_fld[F_WEEKDAY] > WDAY_MAX)  n_fld[F_WEEKDAY] = 7'd1;
                    n_wr = 1'b1;
                end
            end
            OP_DEC: begin
                if (r_mode) begin
                    n_fld[r_cursor] = r_fld[r_cursor] - 7'd1;
                    if (n_fld[F_YEAR] > YEAR_MAX) n_fld[F_YEAR] = YEAR_MAX;
                    if (n_fld[F_MONTH] == 7'd0)   n_fld[F_MONTH] = MONTH_MAX;
                    w_len = month_len(n_fld[F_MONTH], n_fld[F_YEAR]);
                    if (n_fld[F_DAY] == 7'd0) n_fld[F_DAY] = {2'b00, w_len};
                    // only short months wrap an overlong day back to one
                    if (w_len != DAYS_LONG && n_fld[F_DAY] > {2'b00, w_len}) begin
                        n_fld[F_DAY] = 7'd1;
                    end
                    if (n_fld[F_HOUR] > HOUR_MAX)   n_fld[F_HOUR] = HOUR_MAX;
                    if (n_fld[F_MINUTE] > MIN_MAX)  n_fld[F_MINUTE] = MIN_MAX;
                    if (n_fld[F_SECOND] > MIN_MAX)  n_fld[F_SECOND] = MIN_MAX;
                    if (n_fld[F_WEEKDAY] == 7'd0)   n_fld[F_WEEKDAY] = WDAY_MAX;
                    n_wr = 1'b1;
                end
            end
            OP_LOAD: begin
                // ignored while editing
                if (!r_mode) begin
                    n_fld[F_YEAR]    = i_item.load_year;
                    n_fld[F_MONTH]   = {3'b000, i_item.load_month};
                    n_fld[F_DAY]     = {2'b00, i_item.load_day};
                    n_fld[F_HOUR]    = {2'b00, i_item.load_hour};
                    n_fld[F_MINUTE]  = {1'b0, i_item.load_minute};
                    n_fld[F_SECOND]  = {1'b0, i_item.load_second};
                    n_fld[F_WEEKDAY] = {4'b0000, i_item.load_weekday};
                end
            end
            default: begin
                n_wr = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= F_YEAR;
            r_mode   <= 1'b0;
            r_wr     <= 1'b0;
        end else if (i_fire) begin
            r_cursor <= n_cursor;
            r_mode   <= n_mode;
            r_wr     <= n_wr;
        end
    end

    // time fields, undefined until loaded
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_fld <= n_fld;
        end
    end

    // state doubles as the result register; it only moves when the beat is taken
    assign o_year    = r_fld[F_YEAR];
    assign o_month   = r_fld[F_MONTH][3:0];
    assign o_day     = r_fld[F_DAY][4:0];
    assign o_hour    = r_fld[F_HOUR][4:0];
    assign o_minute  = r_fld[F_MINUTE][5:0];
    assign o_second  = r_fld[F_SECOND][5:0];
    assign o_weekday = r_fld[F_WEEKDAY][2:0];
    assign o_cursor  = r_cursor;
    assign o_mode    = r_mode;
    assign o_wr      = r_wr;

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= F_WEEKDAY)
        else $error("cursor past last field");

    a_wr_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr |-> r_mode)
        else $error("write strobe outside set mode");

    a_mode_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (w_op == OP_MODE) |=> (r_mode != $past(r_mode)) && (r_wr == r_mode))
        else $error("mode key did not toggle set mode");

    a_next_show: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (w_op == OP_NEXT) && !r_mode |=> $stable(r_cursor) && !r_wr)
        else $error("next key acted in show mode");

endmodule
